/* hw/rtl/gli_pkg.sv */
// ============================================================================
// Grid-to-layer interpolator package
// Field widths, beat types and shared constants for the interpolator.
// ============================================================================
package gli_pkg;

    // Field widths
    localparam int DEPTH_W       = 20;
    localparam int VAL_W         = 16;
    localparam int SUB_W         = 4;

    // Largest sublayer count; the register field cannot exceed it.
    localparam int MAX_SUBLAYERS = 15;

    // Layers per interval reach MAX_SUBLAYERS + 1, so this width holds n.
    localparam int N_W           = $clog2(MAX_SUBLAYERS + 2);
    localparam int J_W           = $clog2(MAX_SUBLAYERS + 1);

    // Remainder of a division by n, and the midpoint residue below 2n.
    localparam int REM_W         = $clog2(MAX_SUBLAYERS + 1);
    localparam int RES_W         = N_W;

    // Three interpolated properties: p velocity, s velocity, density.
    localparam int NUM_LANES     = 3;
    localparam int LANE_W        = 2;

    // The shared divider walks one dividend bit per cycle.
    localparam int DIV_STEPS     = DEPTH_W;
    localparam int CNT_W         = $clog2(DIV_STEPS);

    // One grid point
    typedef struct packed {
        logic [DEPTH_W-1:0] depth_m;
        logic [VAL_W-1:0]   p_velocity;
        logic [VAL_W-1:0]   s_velocity;
        logic [VAL_W-1:0]   density;
        logic               last_point;
    } gli_in_t;

    // One layer
    typedef struct packed {
        logic [DEPTH_W-1:0] thickness_m;
        logic [VAL_W-1:0]   layer_p_velocity;
        logic [VAL_W-1:0]   layer_s_velocity;
        logic [VAL_W-1:0]   layer_density;
        logic               half_space;
        logic               last_of_run;
    } gli_out_t;

endpackage

/* hw/rtl/grid_to_layer_interpolator.sv */
// ============================================================================
// Grid-to-layer interpolator
// Turns a depth profile of grid points into layers of equal thickness with
// midpoint-sampled properties, an optional water layer and a terminating half space.
// ============================================================================
// A grid point is taken whenever in_ready is high; the block then stays busy
// until all layers caused by that point have entered the output register. For
// an interior point with n = sublayer_count + 1 layers per interval, one shared
// restoring divider divides the depth step and the three property steps by n,
// one bit per cycle, and the layers then leave at one per cycle while out_ready
// stays high; a last point then also emits its half space. The first point of
// a profile produces no layer, or only the half space when it is also the last
// point; a water layer is emitted directly, without a division.
// The sublayer count in force when a point is accepted applies to the whole
// interval that ends at that point.
module grid_to_layer_interpolator (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [gli_pkg::SUB_W-1:0]     cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  gli_pkg::gli_in_t              in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output gli_pkg::gli_out_t             out_data
);
    import gli_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_EMIT,
        ST_WATER,
        ST_HALF
    } state_t;

    // Division slots: the depth step first, then one per property lane.
    localparam logic [LANE_W-1:0] SLOT_THICK = LANE_W'(0);
    localparam logic [LANE_W-1:0] SLOT_LAST  = LANE_W'(NUM_LANES);

    state_t                 state_reg;
    logic [SUB_W-1:0]       sub_reg;
    logic [N_W-1:0]         n_reg;
    logic [1:0]             points_seen_reg;
    logic                   water_top_reg;
    gli_in_t                item_reg;
    logic [DEPTH_W-1:0]     prev_depth_reg;
    logic [VAL_W-1:0]       prev_val_reg [NUM_LANES];
    logic [DEPTH_W-1:0]     thick_reg;

    // Divider registers
    logic [DEPTH_W-1:0]     quo_reg;
    logic [REM_W-1:0]       rem_reg;
    logic [CNT_W-1:0]       div_cnt_reg;
    logic [LANE_W-1:0]      div_idx_reg;

    // Per-lane step magnitude, sign, increment and running sample
    logic [VAL_W-1:0]       mag_reg    [NUM_LANES];
    logic                   neg_reg    [NUM_LANES];
    logic [VAL_W:0]         step_q_reg [NUM_LANES];
    logic [REM_W-1:0]       step_r_reg [NUM_LANES];
    logic [VAL_W-1:0]       acc_q_reg  [NUM_LANES];
    logic [RES_W-1:0]       acc_r_reg  [NUM_LANES];
    logic [J_W-1:0]         j_reg;

    logic                   out_valid_reg;
    gli_out_t               out_reg;

    // Handshakes
    logic                   in_fire;
    logic                   out_free;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // Current point values arranged by lane, and the step from the previous point.
    logic [VAL_W-1:0]       in_val    [NUM_LANES];
    logic [VAL_W-1:0]       in_mag    [NUM_LANES];
    logic                   in_neg    [NUM_LANES];
    logic [DEPTH_W-1:0]     in_diff;

    always_comb
    begin
        in_val[0] = in_data.p_velocity;
        in_val[1] = in_data.s_velocity;
        in_val[2] = in_data.density;
    end

    for (genvar k = 0; k < NUM_LANES; k++) begin : g_step
        logic [VAL_W:0] delta;
        assign delta     = {1'b0, in_val[k]} - {1'b0, prev_val_reg[k]};
        assign in_neg[k] = delta[VAL_W];
        assign in_mag[k] = in_neg[k] ? VAL_W'(-delta) : delta[VAL_W-1:0];
    end

    // Decreasing depth gives a zero-thickness interval.
    assign in_diff = (in_data.depth_m >= prev_depth_reg) ?
                     (in_data.depth_m - prev_depth_reg) : '0;

    // One restoring division step: shift in the next dividend bit, subtract n if it fits.
    logic [REM_W:0]         div_trial;
    logic                   div_fit;
    logic [REM_W-1:0]       rem_step;
    logic [DEPTH_W-1:0]     quo_step;

    assign div_trial = {rem_reg, quo_reg[DEPTH_W-1]};
    assign div_fit   = ({1'b0, div_trial} >= {1'b0, n_reg});
    assign rem_step  = div_fit ? REM_W'(div_trial - (REM_W+1)'(n_reg))
                               : div_trial[REM_W-1:0];
    assign quo_step  = {quo_reg[DEPTH_W-2:0], div_fit};

    // Turn a magnitude division into a floored signed one and derive the first sample.
    logic [LANE_W-1:0]      lane_sel;
    logic [VAL_W:0]         fix_q;
    logic [REM_W-1:0]       fix_r;
    logic [VAL_W+1:0]       fix_half;
    logic [RES_W-1:0]       fix_res;

    assign lane_sel = div_idx_reg - LANE_W'(1);

    always_comb
    begin
        fix_q = {1'b0, quo_step[VAL_W-1:0]};
        fix_r = rem_step;
        if (neg_reg[lane_sel])
        begin
            if (rem_step != '0)
            begin
                fix_q = ~fix_q;
                fix_r = REM_W'(n_reg - N_W'(rem_step));
            end
            else
            begin
                fix_q = -fix_q;
            end
        end
        fix_half = ({fix_q[VAL_W], fix_q} + (VAL_W+2)'(1)) >>> 1;
        fix_res  = fix_q[0] ? RES_W'(fix_r) : RES_W'(fix_r) + RES_W'(n_reg);
    end

    // Per-lane advance to the next midpoint sample.
    logic [VAL_W-1:0]       acc_q_next [NUM_LANES];
    logic [RES_W-1:0]       acc_r_next [NUM_LANES];
    logic [RES_W:0]         two_n;

    assign two_n = {n_reg, 1'b0};

    for (genvar k = 0; k < NUM_LANES; k++) begin : g_lane
        logic [RES_W:0] r_sum;
        logic           wrap;
        assign r_sum         = {1'b0, acc_r_reg[k]} + {1'b0, step_r_reg[k], 1'b0};
        assign wrap          = (r_sum >= two_n);
        assign acc_r_next[k] = wrap ? RES_W'(r_sum - two_n) : r_sum[RES_W-1:0];
        assign acc_q_next[k] = acc_q_reg[k] + step_q_reg[k][VAL_W-1:0]
                               + VAL_W'(wrap);
    end

    logic                   last_layer;
    assign last_layer = ({1'b0, j_reg} == (n_reg - N_W'(1)));

    // Sequencer, datapath and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            sub_reg         <= '0;
            n_reg           <= N_W'(1);
            points_seen_reg <= '0;
            water_top_reg   <= 1'b0;
            item_reg        <= '0;
            prev_depth_reg  <= '0;
            thick_reg       <= '0;
            quo_reg         <= '0;
            rem_reg         <= '0;
            div_cnt_reg     <= '0;
            div_idx_reg     <= SLOT_THICK;
            j_reg           <= '0;
            out_valid_reg   <= 1'b0;
            out_reg         <= '0;
            for (int k = 0; k < NUM_LANES; k++)
            begin
                prev_val_reg[k] <= '0;
                mag_reg[k]      <= '0;
                neg_reg[k]      <= 1'b0;
                step_q_reg[k]   <= '0;
                step_r_reg[k]   <= '0;
                acc_q_reg[k]    <= '0;
                acc_r_reg[k]    <= '0;
            end
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                sub_reg <= cfg_data;
            end

            // A pending beat leaves unless a new one is loaded below.
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_fire)
                    begin
                        item_reg       <= in_data;
                        n_reg          <= N_W'(sub_reg) + N_W'(1);
                        prev_depth_reg <= in_data.depth_m;
                        for (int k = 0; k < NUM_LANES; k++)
                        begin
                            prev_val_reg[k] <= in_val[k];
                            acc_q_reg[k]    <= prev_val_reg[k];
                            mag_reg[k]      <= in_mag[k];
                            neg_reg[k]      <= in_neg[k];
                        end
                        thick_reg   <= in_diff;
                        quo_reg     <= in_diff;
                        rem_reg     <= '0;
                        div_cnt_reg <= '0;
                        div_idx_reg <= SLOT_THICK;
                        j_reg       <= '0;

                        // Pick the work for this point.
                        if (points_seen_reg == 2'd0)
                        begin
                            state_reg <= in_data.last_point ? ST_HALF : ST_IDLE;
                        end
                        else if (points_seen_reg == 2'd1 && water_top_reg)
                        begin
                            state_reg <= ST_WATER;
                        end
                        else
                        begin
                            state_reg <= ST_DIV;
                        end

                        // Profile bookkeeping
                        if (in_data.last_point)
                        begin
                            points_seen_reg <= '0;
                            water_top_reg   <= 1'b0;
                        end
                        else
                        begin
                            if (points_seen_reg == 2'd0)
                            begin
                                water_top_reg <= (in_data.s_velocity == '0);
                            end
                            if (points_seen_reg != 2'd2)
                            begin
                                points_seen_reg <= points_seen_reg + 2'd1;
                            end
                        end
                    end
                end

                ST_DIV:
                begin
                    quo_reg     <= quo_step;
                    rem_reg     <= rem_step;
                    div_cnt_reg <= div_cnt_reg + CNT_W'(1);
                    if (div_cnt_reg == CNT_W'(DIV_STEPS - 1))
                    begin
                        // Store the finished quotient, then start the next slot.
                        if (div_idx_reg == SLOT_THICK)
                        begin
                            thick_reg <= quo_step;
                        end
                        else
                        begin
                            step_q_reg[lane_sel] <= fix_q;
                            step_r_reg[lane_sel] <= fix_r;
                            acc_q_reg[lane_sel]  <= acc_q_reg[lane_sel]
                                                    + fix_half[VAL_W-1:0];
                            acc_r_reg[lane_sel]  <= fix_res;
                        end
                        div_cnt_reg <= '0;
                        rem_reg     <= '0;
                        if (div_idx_reg == SLOT_LAST)
                        begin
                            state_reg <= ST_EMIT;
                        end
                        else
                        begin
                            div_idx_reg <= div_idx_reg + LANE_W'(1);
                            quo_reg     <= DEPTH_W'(mag_reg[div_idx_reg]);
                        end
                    end
                end

                ST_EMIT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg            <= 1'b1;
                        out_reg.thickness_m      <= thick_reg;
                        out_reg.layer_p_velocity <= acc_q_reg[0];
                        out_reg.layer_s_velocity <= acc_q_reg[1];
                        out_reg.layer_density    <= acc_q_reg[2];
                        out_reg.half_space       <= 1'b0;
                        out_reg.last_of_run      <= last_layer && !item_reg.last_point;
                        for (int k = 0; k < NUM_LANES; k++)
                        begin
                            acc_q_reg[k] <= acc_q_next[k];
                            acc_r_reg[k] <= acc_r_next[k];
                        end
                        j_reg <= j_reg + J_W'(1);
                        if (last_layer)
                        begin
                            state_reg <= item_reg.last_point ? ST_HALF : ST_IDLE;
                        end
                    end
                end

                ST_WATER:
                begin
                    // Water layer: whole interval, top point's values, no shear.
                    if (out_free)
                    begin
                        out_valid_reg            <= 1'b1;
                        out_reg.thickness_m      <= thick_reg;
                        out_reg.layer_p_velocity <= acc_q_reg[0];
                        out_reg.layer_s_velocity <= '0;
                        out_reg.layer_density    <= acc_q_reg[2];
                        out_reg.half_space       <= 1'b0;
                        out_reg.last_of_run      <= !item_reg.last_point;
                        state_reg <= item_reg.last_point ? ST_HALF : ST_IDLE;
                    end
                end

                ST_HALF:
                begin
                    // Half space closes the profile with the last point's values.
                    if (out_free)
                    begin
                        out_valid_reg            <= 1'b1;
                        out_reg.thickness_m      <= '0;
                        out_reg.layer_p_velocity <= item_reg.p_velocity;
                        out_reg.layer_s_velocity <= item_reg.s_velocity;
                        out_reg.layer_density    <= item_reg.density;
                        out_reg.half_space       <= 1'b1;
                        out_reg.last_of_run      <= 1'b1;
                        state_reg                <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    // The divider remainder always stays below the divisor.
    a_rem_below_n: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV |-> rem_reg < REM_W'(n_reg) || n_reg == N_W'(MAX_SUBLAYERS + 1))
        else $error("divider remainder reached the divisor");

    // Midpoint residues stay below 2n while layers are produced.
    a_res_below_two_n: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EMIT |-> {1'b0, acc_r_reg[0]} < two_n
                                 && {1'b0, acc_r_reg[1]} < two_n
                                 && {1'b0, acc_r_reg[2]} < two_n)
        else $error("midpoint residue out of range");

    // The point count saturates at two.
    a_points_sat: assert property (@(posedge clk) disable iff (!rst_n)
        points_seen_reg != 2'd3)
        else $error("point count passed saturation");

    // A half-space beat always closes the run of its point.
    a_half_closes: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.half_space |-> out_reg.last_of_run)
        else $error("half space not marked as last of run");

    // The layer counter never runs past the layer count.
    a_j_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EMIT |-> {1'b0, j_reg} < n_reg)
        else $error("layer counter past layer count");
`endif

endmodule
